// ----- rtl/core/gic_pkg.sv -----
// Shared types, register map constants and helper functions of the grouped interrupt controller.
`default_nettype none

package gic_pkg;

  localparam int unsigned GroupsMax     = 7;
  localparam int unsigned LinesPerGroup = 32;
  localparam int unsigned DefGroups     = 7;
  localparam int unsigned DefLinesUsed  = 200;

  localparam int unsigned WordAddrW  = 5;
  localparam int unsigned GroupIdxW  = 3;
  localparam int unsigned ReqTypeW   = 2;

  // Word offsets inside a bank; group g adds g to each base.
  localparam int unsigned PolOfs      = 7;
  localparam int unsigned PriOfs      = 14;
  localparam int unsigned EnOfs       = 21;
  localparam int unsigned SummaryWord = 31;

  // Bit positions of the summary word.
  localparam int unsigned FiqSumBit = 0;
  localparam int unsigned IrqSumBit = 8;

  localparam logic BankSetup  = 1'b0;
  localparam logic BankStatus = 1'b1;

  typedef enum logic [ReqTypeW-1:0] {
    ReqSample = 2'd0,
    ReqRead   = 2'd1,
    ReqWrite  = 2'd2
  } req_type_e;

  typedef logic [LinesPerGroup-1:0] word_t;

  typedef struct packed {
    logic                  accept;
    logic [ReqTypeW-1:0]   req_type;
    logic                  bank;
    logic [WordAddrW-1:0]  word_addr;
    word_t                 write_data;
    logic [GroupIdxW-1:0]  group_index;
    word_t                 line_levels;
  } req_t;

  typedef struct packed {
    logic fiq_q;
    logic irq_q;
    logic fiq_d;
    logic irq_d;
  } lane_stat_t;

  typedef struct packed {
    word_t read_data;
    logic  irq;
    logic  fiq;
  } result_t;

  // Lines at or beyond lines_used do not exist and never become pending.
  function automatic word_t exist_mask(int unsigned group, int unsigned lines_used);
    word_t m;
    for (int unsigned i = 0; i < LinesPerGroup; i++) begin
      m[i] = ((group * LinesPerGroup + i) < lines_used);
    end
    return m;
  endfunction

  function automatic word_t active_lines(word_t typ, word_t pol, word_t en,
                                         word_t latch, word_t prev, word_t exist);
    return (((prev ^ pol) & ~typ) | (latch & typ)) & en & exist;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/grouped_irq_fiq_interrupt_controller.sv -----
// Top level of the grouped interrupt controller: group lanes, merge and output buffer.
//
// Channel  Direction  Handshake              Beat contents
// in       input      in_valid_i/in_ready_o  req_type, bank, word_addr, write_data,
//                                            group_index, line_levels
// out      output     out_valid_o/out_ready_i read_data, irq_out, fiq_out
//
// While in_ready_o is high, one beat is accepted per cycle and one item per cycle is
// sustained, since every group lane updates its own registers in the cycle of acceptance;
// each result is registered. A two-entry output buffer (output register plus skid) keeps
// the input open while a result waits; in_ready_o drops only when both entries are full.
// Reset puts all setup and status registers to their defaults at once; no clearing pass.
`default_nettype none

module grouped_irq_fiq_interrupt_controller #(
  parameter int unsigned GROUPS     = gic_pkg::DefGroups,
  parameter int unsigned LINES_USED = gic_pkg::DefLinesUsed
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gic_pkg::ReqTypeW-1:0]    req_type_i,
  input  logic                            bank_i,
  input  logic [gic_pkg::WordAddrW-1:0]   word_addr_i,
  input  logic [31:0]                     write_data_i,
  input  logic [gic_pkg::GroupIdxW-1:0]   group_index_i,
  input  logic [31:0]                     line_levels_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [31:0]                     read_data_o,
  output logic                            irq_out_o,
  output logic                            fiq_out_o
);

  gic_pkg::req_t       req;
  gic_pkg::word_t      lane_rd   [GROUPS];
  gic_pkg::lane_stat_t lane_stat [GROUPS];
  gic_pkg::result_t    result;

  logic             accept;
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  gic_pkg::result_t out_q, out_d;
  gic_pkg::result_t skid_q, skid_d;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  assign req.accept      = accept;
  assign req.req_type    = req_type_i;
  assign req.bank        = bank_i;
  assign req.word_addr   = word_addr_i;
  assign req.write_data  = write_data_i;
  assign req.group_index = group_index_i;
  assign req.line_levels = line_levels_i;

  for (genvar g = 0; g < GROUPS; g++) begin : g_lane
    gic_lane #(
      .GROUP_ID   (g),
      .LINES_USED (LINES_USED)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .req_i     (req),
      .rd_word_o (lane_rd[g]),
      .stat_o    (lane_stat[g])
    );
  end

  gic_merge #(
    .GROUPS (GROUPS)
  ) u_merge (
    .req_i       (req),
    .lane_rd_i   (lane_rd),
    .lane_stat_i (lane_stat),
    .result_o    (result)
  );

  // A new beat goes to the output register when it is free or draining, else to the skid.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_ready_i) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_q.read_data;
  assign irq_out_o   = out_q.irq;
  assign fiq_out_o   = out_q.fiq;

endmodule

`default_nettype wire

// ----- rtl/core/gic_lane.sv -----
// One group lane: setup registers, edge latches, sampled levels and masked status.
`default_nettype none

module gic_lane #(
  parameter int unsigned GROUP_ID   = 0,
  parameter int unsigned LINES_USED = gic_pkg::DefLinesUsed
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gic_pkg::req_t       req_i,
  output gic_pkg::word_t      rd_word_o,
  output gic_pkg::lane_stat_t stat_o
);

  localparam gic_pkg::word_t ExistMask = gic_pkg::exist_mask(GROUP_ID, LINES_USED);
  localparam logic [gic_pkg::WordAddrW-1:0] TypeWord = gic_pkg::WordAddrW'(GROUP_ID);
  localparam logic [gic_pkg::WordAddrW-1:0] PolWord  =
    gic_pkg::WordAddrW'(gic_pkg::PolOfs + GROUP_ID);
  localparam logic [gic_pkg::WordAddrW-1:0] PriWord  =
    gic_pkg::WordAddrW'(gic_pkg::PriOfs + GROUP_ID);
  localparam logic [gic_pkg::WordAddrW-1:0] EnWord   =
    gic_pkg::WordAddrW'(gic_pkg::EnOfs + GROUP_ID);

  gic_pkg::word_t type_q, type_d;
  gic_pkg::word_t pol_q, pol_d;
  gic_pkg::word_t pri_q, pri_d;
  gic_pkg::word_t en_q, en_d;
  gic_pkg::word_t latch_q, latch_d;
  gic_pkg::word_t prev_q, prev_d;

  gic_pkg::word_t active_q, active_d;
  gic_pkg::word_t edges;
  logic           sample_hit;
  logic           wr_setup;
  logic           wr_status;

  assign sample_hit = req_i.accept
                   && (req_i.req_type == gic_pkg::ReqSample)
                   && (req_i.group_index == gic_pkg::GroupIdxW'(GROUP_ID));
  assign wr_setup   = req_i.accept && (req_i.req_type == gic_pkg::ReqWrite)
                   && (req_i.bank == gic_pkg::BankSetup);
  assign wr_status  = req_i.accept && (req_i.req_type == gic_pkg::ReqWrite)
                   && (req_i.bank == gic_pkg::BankStatus);

  // Active edge: rising for polarity 0, falling for polarity 1.
  assign edges = ((~prev_q & req_i.line_levels & ~pol_q)
               |  (prev_q & ~req_i.line_levels & pol_q)) & type_q;

  always_comb begin
    type_d  = type_q;
    pol_d   = pol_q;
    pri_d   = pri_q;
    en_d    = en_q;
    latch_d = latch_q;
    prev_d  = prev_q;
    if (sample_hit) begin
      latch_d = latch_q | edges;
      prev_d  = req_i.line_levels;
    end
    if (wr_setup) begin
      if (req_i.word_addr == TypeWord) type_d = req_i.write_data;
      if (req_i.word_addr == PolWord)  pol_d  = req_i.write_data;
      if (req_i.word_addr == PriWord)  pri_d  = req_i.write_data;
      if (req_i.word_addr == EnWord)   en_d   = req_i.write_data;
    end
    if (wr_status && (req_i.word_addr == TypeWord)) begin
      latch_d = latch_q & ~req_i.write_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q  <= '1;
      pol_q   <= '0;
      pri_q   <= '1;
      en_q    <= '0;
      latch_q <= '0;
      prev_q  <= '0;
    end else begin
      type_q  <= type_d;
      pol_q   <= pol_d;
      pri_q   <= pri_d;
      en_q    <= en_d;
      latch_q <= latch_d;
      prev_q  <= prev_d;
    end
  end

  assign active_q = gic_pkg::active_lines(type_q, pol_q, en_q, latch_q, prev_q, ExistMask);
  assign active_d = gic_pkg::active_lines(type_d, pol_d, en_d, latch_d, prev_d, ExistMask);

  assign stat_o.fiq_q = |(active_q & ~pri_q);
  assign stat_o.irq_q = |(active_q & pri_q);
  assign stat_o.fiq_d = |(active_d & ~pri_d);
  assign stat_o.irq_d = |(active_d & pri_d);

  always_comb begin
    rd_word_o = '0;
    if (req_i.bank == gic_pkg::BankSetup) begin
      priority if (req_i.word_addr == TypeWord) rd_word_o = type_q;
      else if (req_i.word_addr == PolWord)      rd_word_o = pol_q;
      else if (req_i.word_addr == PriWord)      rd_word_o = pri_q;
      else if (req_i.word_addr == EnWord)       rd_word_o = en_q;
    end else begin
      priority if (req_i.word_addr == TypeWord) rd_word_o = latch_q;
      else if (req_i.word_addr == PolWord)      rd_word_o = active_q & ~pri_q;
      else if (req_i.word_addr == PriWord)      rd_word_o = active_q & pri_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gic_merge.sv -----
// Merges the lanes: read data select, group summary word and the IRQ and FIQ outputs.
`default_nettype none

module gic_merge #(
  parameter int unsigned GROUPS = gic_pkg::DefGroups
) (
  input  gic_pkg::req_t       req_i,
  input  gic_pkg::word_t      lane_rd_i   [GROUPS],
  input  gic_pkg::lane_stat_t lane_stat_i [GROUPS],
  output gic_pkg::result_t    result_o
);

  gic_pkg::word_t summary;
  gic_pkg::word_t lane_rd_or;
  logic           irq_any;
  logic           fiq_any;

  always_comb begin
    summary    = '0;
    lane_rd_or = '0;
    irq_any    = 1'b0;
    fiq_any    = 1'b0;
    for (int unsigned g = 0; g < GROUPS; g++) begin
      summary[gic_pkg::FiqSumBit + g] = lane_stat_i[g].fiq_q;
      summary[gic_pkg::IrqSumBit + g] = lane_stat_i[g].irq_q;
      lane_rd_or = lane_rd_or | lane_rd_i[g];
      irq_any    = irq_any | lane_stat_i[g].irq_d;
      fiq_any    = fiq_any | lane_stat_i[g].fiq_d;
    end
  end

  always_comb begin
    result_o.read_data = '0;
    if (req_i.req_type == gic_pkg::ReqRead) begin
      if ((req_i.bank == gic_pkg::BankStatus)
          && (req_i.word_addr == gic_pkg::WordAddrW'(gic_pkg::SummaryWord))) begin
        result_o.read_data = summary;
      end else begin
        result_o.read_data = lane_rd_or;
      end
    end
    result_o.irq = irq_any;
    result_o.fiq = fiq_any;
  end

endmodule

`default_nettype wire
